// File: rtl/windowed_relay_p_valve_control_macros.svh
// Assertion macros for the windowed relay valve controller checker.
// Depends on i_clk and i_rst_n being visible where the macros expand.
`ifndef WINDOWED_RELAY_P_VALVE_CONTROL_MACROS_SVH
`define WINDOWED_RELAY_P_VALVE_CONTROL_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define WRPV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define WRPV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wrpv_pkg.sv
// Shared types, codes and constants of the windowed relay valve controller.
// No dependencies.
`default_nettype none

package wrpv_pkg;

    localparam int TIME_BITS = 32;
    typedef logic [TIME_BITS-1:0] t_time;

    localparam logic [15:0] WINDOW_RST   = 16'd1000;
    localparam logic [15:0] DEADBAND_RST = 16'd200;
    localparam logic [15:0] GAIN_RST     = 16'd2560;
    localparam logic [15:0] DUMP_LIMIT   = 16'd100;
    localparam logic [15:0] MIN_PULSE    = 16'd20;
    localparam logic [31:0] FULL_SCALE   = 32'd25600000;
    // FULL_SCALE = 3125 << 13
    localparam int          DIV_SHIFT    = 13;
    // floor(x / 3125) = (x * RECIP_ODD) >> RECIP_SHIFT for any 28-bit x
    localparam logic [28:0] RECIP_ODD    = 29'd351843721;
    localparam int          RECIP_SHIFT  = 40;

    typedef enum logic [1:0] {
        RELAY_NONE  = 2'd0,
        RELAY_OPEN  = 2'd1,
        RELAY_CLOSE = 2'd2
    } t_relay;

    typedef enum logic [1:0] {
        CFG_WINDOW   = 2'd0,
        CFG_DEADBAND = 2'd1,
        CFG_GAIN     = 2'd2,
        CFG_NOZZLE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_FIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic eval;
        logic mul1;
        logic mul2;
        logic mul3;
        logic fin;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_calc;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/wrpv_ctrl.sv
// Controller state machine of the windowed relay valve controller.
// Depends on wrpv_pkg; drives wrpv_datapath through t_cmd.
`default_nettype none

module wrpv_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wrpv_pkg::t_status i_status,
    output wrpv_pkg::t_cmd   o_cmd
);
    import wrpv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_EVAL;
            S_EVAL:  n_state = i_status.need_calc ? S_MUL1 : S_EMIT;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_FIN;
            S_FIN:   n_state = S_EMIT;
            S_EMIT:  if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EVAL:  o_cmd.eval = 1'b1;
            S_MUL1:  o_cmd.mul1 = 1'b1;
            S_MUL2:  o_cmd.mul2 = 1'b1;
            S_MUL3:  o_cmd.mul3 = 1'b1;
            S_FIN:   o_cmd.fin = 1'b1;
            S_EMIT:  o_cmd.emit = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/wrpv_datapath.sv
// Datapath of the windowed relay valve controller: config, window state,
// gain multiplies, reciprocal divide and output register. Depends on wrpv_pkg.
`default_nettype none

module wrpv_datapath (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wrpv_pkg::t_cmd    i_cmd,
    output wrpv_pkg::t_status o_status,
    input  wire               i_cfg_we,
    input  wire [1:0]         i_cfg_index,
    input  wire [15:0]        i_cfg_data,
    input  wire [71:0]        i_in_data,
    output logic [23:0]       o_out_data,
    output logic              o_out_valid,
    input  wire               i_out_ready
);
    import wrpv_pkg::*;

    logic [15:0] r_window;
    logic [15:0] r_deadband;
    logic [15:0] r_gain;
    logic        r_nozzle;

    t_time       r_win_begin;
    logic [15:0] r_pulse_len;
    t_relay      r_active;

    t_time       r_now;
    logic [15:0] r_pressure;
    logic [15:0] r_target;
    logic        r_enable;
    logic        r_hold;

    logic        r_rise;
    logic [15:0] r_abs_err;
    logic [31:0] r_p;
    logic [40:0] r_n;
    logic        r_sat;
    logic [15:0] r_q;

    logic [23:0] r_out_data;
    logic        r_out_valid;

    t_time       elapsed;
    logic        relay_off;
    logic        new_win;
    logic        rise;
    logic [15:0] abs_err;
    logic        dump;
    logic [56:0] quot_prod;
    logic [15:0] pulse;
    t_relay      dir_relay;
    t_relay      dump_relay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= WINDOW_RST;
            r_deadband <= DEADBAND_RST;
            r_gain     <= GAIN_RST;
            r_nozzle   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WINDOW:   r_window   <= i_cfg_data;
                CFG_DEADBAND: r_deadband <= i_cfg_data;
                CFG_GAIN:     r_gain     <= i_cfg_data;
                CFG_NOZZLE:   r_nozzle   <= i_cfg_data[0];
                default:      r_nozzle   <= r_nozzle;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now      <= t_time'(i_in_data[31:0]);
            r_pressure <= i_in_data[47:32];
            r_target   <= i_in_data[63:48];
            r_enable   <= i_in_data[64];
            r_hold     <= i_in_data[65];
        end
    end

    always_comb begin
        elapsed   = r_now - r_win_begin;
        relay_off = (r_active != RELAY_NONE) && (elapsed >= t_time'(r_pulse_len));
        new_win   = elapsed >= t_time'(r_window);
        rise      = r_target > r_pressure;
        abs_err   = rise ? (r_target - r_pressure) : (r_pressure - r_target);
        dump      = r_target < DUMP_LIMIT;
        dump_relay = r_nozzle ? RELAY_CLOSE : RELAY_OPEN;
        if (r_nozzle) begin
            dir_relay = r_rise ? RELAY_OPEN : RELAY_CLOSE;
        end else begin
            dir_relay = r_rise ? RELAY_CLOSE : RELAY_OPEN;
        end
        pulse = r_sat ? r_window : r_q;
    end

    always_comb begin
        quot_prod = r_n[40:DIV_SHIFT] * RECIP_ODD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_begin <= '0;
            r_pulse_len <= '0;
            r_active    <= RELAY_NONE;
        end else if (i_cmd.eval && !r_hold) begin
            if (relay_off) begin
                r_active <= RELAY_NONE;
            end
            if (new_win) begin
                r_win_begin <= r_now;
                r_active    <= RELAY_NONE;
                r_pulse_len <= '0;
                if (r_enable && dump) begin
                    r_pulse_len <= r_window;
                    r_active    <= dump_relay;
                end
            end
        end else if (i_cmd.fin && (pulse >= MIN_PULSE)) begin
            r_pulse_len <= pulse;
            r_active    <= dir_relay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_rise    <= rise;
            r_abs_err <= abs_err;
        end
        if (i_cmd.mul1) begin
            r_p <= r_gain * r_abs_err;
        end
        if (i_cmd.mul2) begin
            r_n   <= r_window * r_p[24:0];
            r_sat <= r_p >= FULL_SCALE;
        end
        if (i_cmd.mul3) begin
            r_q <= quot_prod[RECIP_SHIFT+15:RECIP_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {6'b0, r_pulse_len, r_active == RELAY_CLOSE,
                           r_active == RELAY_OPEN};
        end
    end

    always_comb begin
        o_status.need_calc = !r_hold && new_win && r_enable && !dump
                             && (abs_err >= r_deadband);
        o_status.out_free  = !r_out_valid || i_out_ready;
        o_out_data         = r_out_data;
        o_out_valid        = r_out_valid;
    end

endmodule

`default_nettype wire

// File: rtl/windowed_relay_p_valve_control.sv
// Top level of the windowed relay valve controller: controller plus datapath.
// Depends on wrpv_pkg, wrpv_ctrl and wrpv_datapath.
//
//   channel   direction  payload (low bit first)
//   s_axis    in         now_ms[31:0] pressure_mbar[47:32] target_mbar[63:48]
//                        enable[64] panel_hold[65]
//   m_axis    out        open_drive[0] close_drive[1] pulse_ms[17:2]
//   cfg       in         index 0 window, 1 deadband, 2 gain, 3 nozzle mode
//
// An item that starts no pulse computation goes from eval straight to emit; one
// that does passes three dependent multiplies: gain by error, window by that
// product, and a reciprocal multiply for the divide. Input is taken only in idle.
// Reset is synchronous and needs no clearing pass. A stalled m_axis holds the
// next result in the emit state; input ready stays low until it is stored.
`default_nettype none

module windowed_relay_p_valve_control (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [71:0] s_axis_tdata,   // now_ms, pressure_mbar, target_mbar, enable, panel_hold
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // open_drive, close_drive, pulse_ms
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);
    import wrpv_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    wrpv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wrpv_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .o_out_data  (m_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

endmodule

`default_nettype wire

// File: rtl/wrpv_checker.sv
// Port-level checker for the windowed relay valve controller, bound to the top.
// Depends on windowed_relay_p_valve_control_macros.svh.
`default_nettype none

`include "windowed_relay_p_valve_control_macros.svh"

module wrpv_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata
);

    `WRPV_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `WRPV_ASSERT_IMP(a_one_relay, m_axis_tvalid,
        !(m_axis_tdata[0] && m_axis_tdata[1]), "both relays driven")
    `WRPV_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "second item taken while busy")
    `WRPV_ASSERT_IMP(a_pad_zero, m_axis_tvalid,
        m_axis_tdata[23:18] == 6'd0, "result padding not zero")

endmodule

bind windowed_relay_p_valve_control wrpv_checker u_chk (.*);

`default_nettype wire
